[sv/jsu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Escape decoder phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_beat_t;

  // One decode step of the shared unit
  typedef struct packed {
    phase_t          phase_nxt;
    logic [1:0]      count_nxt;
    logic [2:0][7:0] hold_nxt;
    logic            emit;
    logic [7:0]      emit_byte;
    logic            code;
    logic [15:0]     cp;
    logic            end_hex;
    logic [1:0]      tail_n;
  } step_res_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
  localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;

  localparam logic [1:0] UTF8_LEN1 = 2'd1;
  localparam logic [1:0] UTF8_LEN2 = 2'd2;
  localparam logic [1:0] UTF8_LEN3 = 2'd3;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LA && c <= CH_LF_HEX) || (c >= CH_UA && c <= CH_UF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // Value of the leading run of hex digits, first digit in dig[0]
  function automatic logic [15:0] hex_prefix(input logic [3:0][7:0] dig);
    logic [15:0] v;
    logic        run;
    logic [4:0]  h;
    v   = '0;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      h = hex_nibble(dig[k]);
      if (run && h[4]) begin
        v = {v[11:0], h[3:0]};
      end else begin
        run = 1'b0;
      end
    end
    return v;
  endfunction

  function automatic logic [1:0] utf8_len(input logic [15:0] v);
    logic [1:0] n;
    if (v < UTF8_LIMIT1) begin
      n = UTF8_LEN1;
    end else if (v < UTF8_LIMIT2) begin
      n = UTF8_LEN2;
    end else begin
      n = UTF8_LEN3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [15:0] v, input logic [1:0] idx,
                                           input logic [1:0] len);
    logic [7:0] b;
    case (len)
      UTF8_LEN1: b = v[7:0];
      UTF8_LEN2: begin
        if (idx == 2'd0) begin
          b = UTF8_LEAD2 | {3'b000, v[10:6]};
        end else begin
          b = UTF8_CONT | {2'b00, v[5:0]};
        end
      end
      default: begin
        case (idx)
          2'd0:    b = UTF8_LEAD3 | {4'b0000, v[15:12]};
          2'd1:    b = UTF8_CONT | {2'b00, v[11:6]};
          default: b = UTF8_CONT | {2'b00, v[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[sv/jsu_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module jsu_step (
  input  jsu_pkg::phase_t    phase,
  input  logic [1:0]         hcnt,
  input  logic [2:0][7:0]    hold,
  input  logic [7:0]         c,
  input  logic               fin,
  output jsu_pkg::step_res_t res
);
  import jsu_pkg::*;

  always_comb begin
    res.phase_nxt = PH_IDLE;
    res.count_nxt = '0;
    res.hold_nxt  = hold;
    res.emit      = 1'b0;
    res.emit_byte = c;
    res.code      = 1'b0;
    res.cp        = hex_prefix({c, hold});
    res.end_hex   = 1'b0;
    res.tail_n    = '0;
    case (phase)
      PH_ESC: begin
        case (c)
          CH_N: begin
            res.emit      = 1'b1;
            res.emit_byte = CTL_LF;
          end
          CH_R: begin
            res.emit      = 1'b1;
            res.emit_byte = CTL_CR;
          end
          CH_T: begin
            res.emit      = 1'b1;
            res.emit_byte = CTL_TAB;
          end
          CH_U: begin
            // string ends right on the u: nothing held, nothing to replay
            if (fin) begin
              res.end_hex = 1'b1;
            end else begin
              res.phase_nxt = PH_HEX;
            end
          end
          default: res.emit = 1'b1;
        endcase
      end
      PH_HEX: begin
        if (hcnt == 2'd3) begin
          res.code = 1'b1;
        end else begin
          res.hold_nxt[hcnt] = c;
          if (fin) begin
            res.end_hex = 1'b1;
            res.tail_n  = hcnt + 2'd1;
          end else begin
            res.phase_nxt = PH_HEX;
            res.count_nxt = hcnt + 2'd1;
          end
        end
      end
      default: begin
        // a trailing backslash passes as itself
        if (c == CH_BSLASH && !fin) begin
          res.phase_nxt = PH_ESC;
        end else begin
          res.emit = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON string body decoder: one escaped byte per input beat, zero to
// three decoded bytes per input, run_end set on the last byte caused by each
// input. A single decode-step unit, under a small sequencer, handles one byte
// per cycle while the output does not block it, and the block accepts no new
// beat until the current one is fully handed off. A plain byte passes through
// S_FEED and S_FLUSH; a byte ending a \u escape also passes through S_CODE,
// which emits its UTF-8 bytes (1 to 3) in turn; a string that ends inside a \u
// escape replays its held digits through the step unit. Each emitted byte waits
// on out_stall through a one-deep pending register ahead of the output register.
module json_string_unescape_utf8 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsu_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jsu_pkg::out_beat_t  out_data
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FEED,
    S_CODE,
    S_FLUSH
  } state_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [2:0][7:0] hold_r, hold_nxt;
  logic [2:0][7:0] q_r, q_nxt;
  logic [1:0]      qidx_r, qidx_nxt;
  logic [1:0]      qlast_r, qlast_nxt;
  logic            qfin_r, qfin_nxt;
  logic            more_r, more_nxt;
  logic [15:0]     cp_r, cp_nxt;
  logic [1:0]      clen_r, clen_nxt;
  logic [1:0]      cidx_r, cidx_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [7:0]      pend_b_r, pend_b_nxt;
  logic            out_v_r, out_v_nxt;
  out_beat_t       out_d_r, out_d_nxt;

  step_res_t       res;
  logic            more;
  logic            out_free;
  logic            blocked;
  logic            push;
  out_beat_t       push_d;

  assign more     = qidx_r != qlast_r;
  assign out_free = !out_v_r || !out_stall;
  assign blocked  = pend_v_r && !out_free;

  jsu_step u_step (
    .phase (phase_r),
    .hcnt  (hcnt_r),
    .hold  (hold_r),
    .c     (q_r[qidx_r]),
    .fin   (qfin_r && !more),
    .res   (res)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hold_nxt   = hold_r;
    q_nxt      = q_r;
    qidx_nxt   = qidx_r;
    qlast_nxt  = qlast_r;
    qfin_nxt   = qfin_r;
    more_nxt   = more_r;
    cp_nxt     = cp_r;
    clen_nxt   = clen_r;
    cidx_nxt   = cidx_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    push       = 1'b0;
    push_d     = '{out_byte: pend_b_r, run_end: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_nxt[0]  = in_data.in_byte;
          qidx_nxt  = '0;
          qlast_nxt = '0;
          qfin_nxt  = in_data.last;
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        if (!blocked) begin
          phase_nxt = res.phase_nxt;
          hcnt_nxt  = res.count_nxt;
          hold_nxt  = res.hold_nxt;
          if (res.emit) begin
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_b_nxt = res.emit_byte;
          end
          if (res.end_hex) begin
            // replay the held digits as the tail of the string
            q_nxt     = res.hold_nxt;
            qidx_nxt  = '0;
            qlast_nxt = res.tail_n - 2'd1;
            qfin_nxt  = 1'b1;
            state_nxt = (res.tail_n == 2'd0) ? S_FLUSH : S_FEED;
          end else begin
            more_nxt = more;
            if (more) begin
              qidx_nxt = qidx_r + 2'd1;
            end
            if (res.code) begin
              cp_nxt    = res.cp;
              clen_nxt  = utf8_len(res.cp);
              cidx_nxt  = '0;
              state_nxt = S_CODE;
            end else begin
              state_nxt = more ? S_FEED : S_FLUSH;
            end
          end
        end
      end
      S_CODE: begin
        if (!blocked) begin
          push       = pend_v_r;
          pend_v_nxt = 1'b1;
          pend_b_nxt = utf8_byte(cp_r, cidx_r, clen_r);
          cidx_nxt   = cidx_r + 2'd1;
          if (cidx_r == clen_r - 2'd1) begin
            state_nxt = more_r ? S_FEED : S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_d.run_end = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_d_nxt = out_d_r;
    out_v_nxt = out_v_r;
    if (push) begin
      out_v_nxt = 1'b1;
      out_d_nxt = push_d;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_IDLE;
      hcnt_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r   <= hold_nxt;
    q_r      <= q_nxt;
    qidx_r   <= qidx_nxt;
    qlast_r  <= qlast_nxt;
    qfin_r   <= qfin_nxt;
    more_r   <= more_nxt;
    cp_r     <= cp_nxt;
    clen_r   <= clen_nxt;
    cidx_r   <= cidx_nxt;
    pend_b_r <= pend_b_nxt;
    out_d_r  <= out_d_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending byte left behind on return to idle");

  a_hcnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r != 2'd0 |-> phase_r == PH_HEX)
    else $error("hex digits held outside a u escape");

  a_queue_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FEED |-> qidx_r <= qlast_r)
    else $error("replay index past its last entry");

  a_code_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CODE |-> (cidx_r < clen_r) && (clen_r != 2'd0))
    else $error("UTF-8 byte index out of range");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

endmodule

`default_nettype wire
